### rtl/erd_pkg.sv
package erd_pkg;

    localparam int unsigned LANES = 8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_OFFSET = 2'd3
    } phase_t;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam int unsigned SIGN_BIT_POS = 7;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       list_start;
        logic       list_last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        list_done;
        logic        sparse;
        logic [63:0] cluster_count;
        logic [63:0] start_lcn;
    } out_beat_t;

endpackage

### rtl/extent_runlist_decoder.sv
// Extent run list decoder. Takes an encoded run list one byte per beat on the
// s_ channel (run_byte, with list_start on the first header byte of a list and
// list_last on the final byte of the available area) and returns one beat on
// the m_ channel for every completed run (status 0: length, absolute start
// cluster or sparse flag), for a zero header end marker (status 1) and for a
// run cut short by list_last (status 2). Offsets are signed deltas summed into
// a running cluster number modulo 2^64; length and offset bytes past the
// eighth are consumed and ignored. Throughput is one byte per clock while the
// result register can load: each byte is held in the input register and is
// decoded by the step logic (byte placement plus one 64-bit add) straight into
// the result register, which presents the result on m_.
// The input register accepts a byte while a result waits in the output
// register; back-pressure reaches s_ready only once both are full.
module extent_runlist_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  erd_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output erd_pkg::out_beat_t m_data
);
    import erd_pkg::*;

    logic      beat_valid;
    in_beat_t  beat_data;
    logic      out_can_load;
    logic      step_fire;
    logic      step_emit;
    out_beat_t step_result;

    // step logic advances only when the result register has room
    assign step_fire = beat_valid && out_can_load;

    erd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (step_fire),
        .beat_valid (beat_valid),
        .beat_data  (beat_data)
    );

    erd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (step_fire),
        .beat    (beat_data),
        .emit    (step_emit),
        .result  (step_result)
    );

    erd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_fire && step_emit),
        .load_data (step_result),
        .can_load  (out_can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // end marker and truncation always close the list
    a_term_closes_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_RUN) |-> m_data.list_done)
        else $error("end or truncation beat without list_done");

    // sparse runs carry no start cluster
    a_sparse_zero_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sparse) |-> (m_data.start_lcn == 64'd0 && m_data.status == ST_RUN))
        else $error("sparse beat with nonzero start");

    // held input beat is not overwritten while the step logic is stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_valid && !step_fire) |=> (beat_valid && $stable(beat_data)))
        else $error("input register lost a stalled beat");

    // the step never emits into a full, stalled result register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !step_fire)
        else $error("result register overrun");

endmodule

### rtl/erd_in_stage.sv
module erd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  erd_pkg::in_beat_t s_data,
    input  logic              take,
    output logic              beat_valid,
    output erd_pkg::in_beat_t beat_data
);
    import erd_pkg::*;

    logic     valid_reg;
    in_beat_t data_reg;

    // register frees up in the same cycle the step logic takes it
    assign s_ready    = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // cleared so the phase decode never sees an unknown list_start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule

### rtl/erd_step.sv
module erd_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  erd_pkg::in_beat_t  beat,
    output logic               emit,
    output erd_pkg::out_beat_t result
);
    import erd_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  off_left_reg, off_left_next;
    logic [3:0]  idx_reg,      idx_next;
    logic [3:0]  off_width_reg, off_width_next;
    logic [63:0] len_acc_reg,  len_acc_next;
    logic [63:0] delta_reg,    delta_next;
    logic [63:0] run_lcn_reg,  run_lcn_next;

    phase_t      cur_phase;
    logic [63:0] cur_run;
    logic [63:0] field_acc;
    logic [63:0] placed;
    logic [63:0] delta_ext;
    logic [63:0] new_lcn;
    logic [3:0]  left_dec;
    logic        finished;
    logic        cut_short;

    function automatic logic [63:0] place_byte(input logic [63:0] acc,
                                               input logic [7:0]  b,
                                               input logic [3:0]  idx);
        logic [63:0] r;
        r = acc;
        for (int k = 0; k < LANES; k++) begin
            if (idx == 4'(k)) begin
                r[8*k +: 8] = r[8*k +: 8] | b;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] sign_fill(input logic [3:0] width);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < LANES; k++) begin
            if (4'(k) >= width) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // list start forces a header and clears the running cluster
    assign cur_phase = beat.list_start ? PH_HEADER : phase_reg;
    assign cur_run   = beat.list_start ? 64'd0 : run_lcn_reg;

    // one lane update and one countdown serve both fields
    assign field_acc = (cur_phase == PH_LENGTH) ? len_acc_reg : delta_reg;
    assign placed    = place_byte(field_acc, beat.run_byte, idx_reg);
    assign left_dec  = ((cur_phase == PH_LENGTH) ? len_left_reg : off_left_reg) - 4'd1;

    // short negative delta: fill the lanes above the field
    assign delta_ext = (off_width_reg < 4'(LANES) && beat.run_byte[SIGN_BIT_POS])
                     ? (placed | sign_fill(off_width_reg)) : placed;
    assign new_lcn   = cur_run + delta_ext;

    assign finished  = (cur_phase == PH_HEADER && beat.run_byte == 8'd0)
                    || (cur_phase == PH_LENGTH && left_dec == 4'd0 && off_left_reg == 4'd0)
                    || (cur_phase == PH_OFFSET && left_dec == 4'd0);

    // area ran out before the run was complete
    assign cut_short = (cur_phase != PH_IDLE) && !finished && beat.list_last;

    // next state
    always_comb begin
        phase_next     = cur_phase;
        len_left_next  = len_left_reg;
        off_left_next  = off_left_reg;
        idx_next       = idx_reg;
        off_width_next = off_width_reg;
        len_acc_next   = len_acc_reg;
        delta_next     = delta_reg;
        run_lcn_next   = cur_run;

        unique case (cur_phase)
            PH_IDLE: begin
                // stray byte outside a list: dropped
            end
            PH_HEADER: begin
                if (beat.run_byte == 8'd0) begin
                    phase_next = PH_IDLE;
                end else begin
                    len_left_next  = beat.run_byte[3:0] & NIBBLE_MASK;
                    off_left_next  = beat.run_byte[7:4] & NIBBLE_MASK;
                    off_width_next = beat.run_byte[7:4] & NIBBLE_MASK;
                    idx_next       = '0;
                    len_acc_next   = '0;
                    delta_next     = '0;
                    phase_next     = (beat.run_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                len_acc_next  = placed;
                len_left_next = left_dec;
                idx_next      = idx_reg + 4'd1;
                if (left_dec == 4'd0) begin
                    if (off_left_reg == 4'd0) begin
                        phase_next = beat.list_last ? PH_IDLE : PH_HEADER;
                    end else begin
                        idx_next   = '0;
                        phase_next = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                delta_next    = placed;
                off_left_next = left_dec;
                idx_next      = idx_reg + 4'd1;
                if (left_dec == 4'd0) begin
                    delta_next   = delta_ext;
                    run_lcn_next = new_lcn;
                    phase_next   = beat.list_last ? PH_IDLE : PH_HEADER;
                end
            end
        endcase

        if (cut_short) begin
            phase_next = PH_IDLE;
        end
    end

    // result beat
    always_comb begin
        emit   = finished || cut_short;
        result = '0;

        unique case (cur_phase)
            PH_IDLE: begin
                result = '0;
            end
            PH_HEADER: begin
                if (finished) begin
                    result.status    = ST_END;
                    result.list_done = 1'b1;
                end
            end
            PH_LENGTH: begin
                if (finished) begin
                    result.status        = ST_RUN;
                    result.list_done     = beat.list_last;
                    result.sparse        = 1'b1;
                    result.cluster_count = placed;
                end
            end
            PH_OFFSET: begin
                if (finished) begin
                    result.status        = ST_RUN;
                    result.list_done     = beat.list_last;
                    result.cluster_count = len_acc_reg;
                    result.start_lcn     = new_lcn;
                end
            end
        endcase

        if (cut_short) begin
            result.status    = ST_TRUNC;
            result.list_done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            len_left_reg  <= '0;
            off_left_reg  <= '0;
            idx_reg       <= '0;
            off_width_reg <= '0;
            len_acc_reg   <= '0;
            delta_reg     <= '0;
            run_lcn_reg   <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            off_left_reg  <= off_left_next;
            idx_reg       <= idx_next;
            off_width_reg <= off_width_next;
            len_acc_reg   <= len_acc_next;
            delta_reg     <= delta_next;
            run_lcn_reg   <= run_lcn_next;
        end
    end

endmodule

### rtl/erd_out_stage.sv
module erd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  erd_pkg::out_beat_t load_data,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output erd_pkg::out_beat_t m_data
);
    import erd_pkg::*;

    logic      valid_reg;
    out_beat_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            data_reg <= load_data;
        end
    end

endmodule
